>>> src/ple_pkg.sv
package ple_pkg;

   localparam int DEPTH      = 16;
   localparam int DATA_WIDTH = 32;

   localparam int IDX_W   = $clog2(DEPTH);
   localparam int COUNT_W = $clog2(DEPTH + 1);

   localparam int CMD_W    = 3;
   localparam int POS_W    = 8;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int ELEM_W   = 32;
   localparam int CNT_FW   = 5;

   localparam int CMP_W = ((POS_W > COUNT_W) ? POS_W : COUNT_W) + 1;

   typedef enum logic [CMD_W-1:0] {
      CMD_INS_FRONT = 3'd0,
      CMD_INS_END   = 3'd1,
      CMD_INS_AT    = 3'd2,
      CMD_DEL_FRONT = 3'd3,
      CMD_DEL_END   = 3'd4,
      CMD_DEL_AT    = 3'd5,
      CMD_DUMP      = 3'd6
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK     = 2'd0,
      ST_BADPOS = 2'd1,
      ST_FULL   = 2'd2,
      ST_EMPTY  = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      OP_HOLD,
      OP_INSERT,
      OP_DELETE,
      OP_ROTATE
   } op_type;

   typedef struct packed {
      op_type           op;
      logic [IDX_W-1:0] pos;
      logic [IDX_W-1:0] last;
   } ctl_type;

   typedef struct packed {
      logic [CMD_W-1:0]   command;
      logic [POS_W-1:0]   position;
      logic [VALUE_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [ELEM_W-1:0]   element;
      logic [CNT_FW-1:0]   element_count;
      logic                last_result;
   } rsp_type;

endpackage

>>> src/ple_cell.sv
module ple_cell (
   input  logic                           clock,
   input  ple_pkg::ctl_type               ctl,
   input  logic [ple_pkg::IDX_W-1:0]      idx,
   input  logic [ple_pkg::DATA_WIDTH-1:0] left,
   input  logic [ple_pkg::DATA_WIDTH-1:0] right,
   input  logic [ple_pkg::DATA_WIDTH-1:0] head,
   input  logic [ple_pkg::DATA_WIDTH-1:0] new_value,
   output logic [ple_pkg::DATA_WIDTH-1:0] value
);

   logic [ple_pkg::DATA_WIDTH-1:0] value_ff;
   logic [ple_pkg::DATA_WIDTH-1:0] value_in;

   always_comb begin
      value_in = value_ff;
      case (ctl.op)
         ple_pkg::OP_INSERT: begin
            if (idx > ctl.pos) begin
               value_in = left;
            end else if (idx == ctl.pos) begin
               value_in = new_value;
            end
         end
         ple_pkg::OP_DELETE: begin
            if (idx >= ctl.pos) begin
               value_in = right;
            end
         end
         ple_pkg::OP_ROTATE: begin
            if (idx < ctl.last) begin
               value_in = right;
            end else if (idx == ctl.last) begin
               value_in = head;
            end
         end
         default: begin
            value_in = value_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

>>> src/ple_chain.sv
module ple_chain (
   input  logic                           clock,
   input  ple_pkg::ctl_type               ctl,
   input  logic [ple_pkg::DATA_WIDTH-1:0] new_value,
   output logic [ple_pkg::DATA_WIDTH-1:0] head
);

   logic [ple_pkg::DATA_WIDTH-1:0] cell_value [ple_pkg::DEPTH];

   for (genvar i = 0; i < ple_pkg::DEPTH; i++) begin : g_cell
      logic [ple_pkg::DATA_WIDTH-1:0] left_value;
      logic [ple_pkg::DATA_WIDTH-1:0] right_value;

      if (i == 0) begin : g_first
         assign left_value = '0;
      end else begin : g_inner_left
         assign left_value = cell_value[i-1];
      end

      if (i == ple_pkg::DEPTH - 1) begin : g_last
         assign right_value = cell_value[0];
      end else begin : g_inner_right
         assign right_value = cell_value[i+1];
      end

      ple_cell u_cell (
         .clock     (clock),
         .ctl       (ctl),
         .idx       (ple_pkg::IDX_W'(i)),
         .left      (left_value),
         .right     (right_value),
         .head      (cell_value[0]),
         .new_value (new_value),
         .value     (cell_value[i])
      );
   end

   assign head = cell_value[0];

endmodule

>>> src/positional_list_engine_unit.sv
// Channel   Ports                        Handshake
// request   start, busy, req_item        taken when start is high and busy is low
// response  rsp_strobe, rsp_item         cannot be held off
//
// Every command except a dump of a non-empty list has a single result; it is on the
// response ports in the cycle after the command is taken.
// A dump of N elements rotates the cell row once per cycle: busy is high while it
// runs, and each of the N results follows in the cycle after its rotation.
// Reset clears the element count and the control state; cell contents stay
// undefined until written. The receiver cannot stall the results.
module positional_list_engine_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  ple_pkg::req_type req_item,
   output logic             rsp_strobe,
   output ple_pkg::rsp_type rsp_item
);

   typedef enum logic {
      S_IDLE,
      S_DUMP
   } state_type;

   state_type                       state_ff;
   state_type                       state_in;
   logic [ple_pkg::COUNT_W-1:0]     count_ff;
   logic [ple_pkg::COUNT_W-1:0]     count_in;
   logic [ple_pkg::IDX_W-1:0]       dump_idx_ff;
   logic [ple_pkg::IDX_W-1:0]       dump_idx_in;
   logic                            rsp_strobe_ff;
   logic                            rsp_strobe_in;
   ple_pkg::rsp_type                rsp_ff;
   ple_pkg::rsp_type                rsp_in;
   ple_pkg::ctl_type                ctl;
   logic [ple_pkg::DATA_WIDTH-1:0]  head;
   logic                            full;
   logic                            empty;
   logic                            ins_bad;
   logic                            del_bad;
   logic                            dump_last;

   assign full    = (count_ff == ple_pkg::COUNT_W'(ple_pkg::DEPTH));
   assign empty   = (count_ff == '0);
   assign ins_bad = (req_item.position == '0) ||
                    (ple_pkg::CMP_W'(req_item.position) >
                     ple_pkg::CMP_W'(count_ff) + ple_pkg::CMP_W'(1));
   assign del_bad = (req_item.position == '0) ||
                    (ple_pkg::CMP_W'(req_item.position) > ple_pkg::CMP_W'(count_ff));
   assign dump_last = (ple_pkg::COUNT_W'(dump_idx_ff) + ple_pkg::COUNT_W'(1) == count_ff);

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      dump_idx_in   = dump_idx_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      ctl.op        = ple_pkg::OP_HOLD;
      ctl.pos       = '0;
      ctl.last      = ple_pkg::IDX_W'(count_ff - ple_pkg::COUNT_W'(1));
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               rsp_strobe_in      = 1'b1;
               rsp_in.status      = ple_pkg::ST_OK;
               rsp_in.element     = '0;
               rsp_in.last_result = 1'b1;
               case (req_item.command) inside
                  ple_pkg::CMD_INS_FRONT, ple_pkg::CMD_INS_END, ple_pkg::CMD_INS_AT: begin
                     if (full) begin
                        rsp_in.status = ple_pkg::ST_FULL;
                     end else if (req_item.command == ple_pkg::CMD_INS_AT && ins_bad) begin
                        rsp_in.status = ple_pkg::ST_BADPOS;
                     end else begin
                        ctl.op   = ple_pkg::OP_INSERT;
                        count_in = count_ff + ple_pkg::COUNT_W'(1);
                        if (req_item.command == ple_pkg::CMD_INS_END) begin
                           ctl.pos = ple_pkg::IDX_W'(count_ff);
                        end else if (req_item.command == ple_pkg::CMD_INS_AT) begin
                           ctl.pos = ple_pkg::IDX_W'(req_item.position - ple_pkg::POS_W'(1));
                        end
                     end
                  end
                  ple_pkg::CMD_DEL_FRONT, ple_pkg::CMD_DEL_END, ple_pkg::CMD_DEL_AT: begin
                     if (empty) begin
                        rsp_in.status = ple_pkg::ST_EMPTY;
                     end else if (req_item.command == ple_pkg::CMD_DEL_AT && del_bad) begin
                        rsp_in.status = ple_pkg::ST_BADPOS;
                     end else begin
                        ctl.op   = ple_pkg::OP_DELETE;
                        count_in = count_ff - ple_pkg::COUNT_W'(1);
                        if (req_item.command == ple_pkg::CMD_DEL_END) begin
                           ctl.pos = ple_pkg::IDX_W'(count_ff - ple_pkg::COUNT_W'(1));
                        end else if (req_item.command == ple_pkg::CMD_DEL_AT) begin
                           ctl.pos = ple_pkg::IDX_W'(req_item.position - ple_pkg::POS_W'(1));
                        end
                     end
                  end
                  ple_pkg::CMD_DUMP: begin
                     if (empty) begin
                        rsp_in.status = ple_pkg::ST_EMPTY;
                     end else begin
                        rsp_strobe_in = 1'b0;
                        state_in      = S_DUMP;
                        dump_idx_in   = '0;
                     end
                  end
                  default: begin
                     rsp_in.status = ple_pkg::ST_OK;
                  end
               endcase
               rsp_in.element_count = ple_pkg::CNT_FW'(count_in);
            end
         end
         S_DUMP: begin
            ctl.op               = ple_pkg::OP_ROTATE;
            rsp_strobe_in        = 1'b1;
            rsp_in.status        = ple_pkg::ST_OK;
            rsp_in.element       = ple_pkg::ELEM_W'(head);
            rsp_in.element_count = ple_pkg::CNT_FW'(count_ff);
            rsp_in.last_result   = dump_last;
            if (dump_last) begin
               state_in    = S_IDLE;
               dump_idx_in = '0;
            end else begin
               dump_idx_in = dump_idx_ff + ple_pkg::IDX_W'(1);
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         dump_idx_ff   <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         dump_idx_ff   <= dump_idx_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      rsp_ff <= rsp_in;
   end

   ple_chain u_chain (
      .clock     (clock),
      .ctl       (ctl),
      .new_value (ple_pkg::DATA_WIDTH'(req_item.value)),
      .head      (head)
   );

   assign busy       = (state_ff == S_DUMP);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

   a_busy_nonempty: assert property (@(posedge clock) disable iff (reset)
      busy |-> count_ff != '0)
      else $error("dump in progress on an empty list");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= ple_pkg::COUNT_W'(ple_pkg::DEPTH))
      else $error("element count exceeds depth");

   a_dump_continues: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_item.last_result |-> busy)
      else $error("dump result without a following result");

   a_count_stable_dump: assert property (@(posedge clock) disable iff (reset)
      busy |=> $stable(count_ff))
      else $error("element count changed during a dump");

endmodule
